/* sv/sgtd_pkg.sv */
// shared types, constants and template tables for the subband group table derive unit
// no dependencies
`default_nettype none

package sgtd_pkg;

	localparam int MASTER_DEPTH = 23;
	localparam int LOW_DEPTH = 12;
	localparam int POW_W = 36;
	localparam int GROUPS_FINE = 22;
	localparam int GROUPS_COARSE = 20;
	localparam int GOAL_48K = 43;
	localparam int GOAL_OTHER = 46;
	localparam int SRC_LOW_FINE = 4;
	localparam int SRC_LOW_COARSE = 2;
	localparam int MIN_PATCH_WIDTH = 3;
	localparam int LIM_NUM = 100000;
	localparam int LIM_DEN = 118504;

	localparam int DEF_MAX_NOISE_GROUPS = 5;
	localparam int DEF_MAX_PATCHES = 6;
	localparam int DEF_MAX_LIMITER_BANDS = 32;

	localparam logic [5:0] TMPL_FINE [0:22] = '{
		6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd26, 6'd28, 6'd30, 6'd32, 6'd34,
		6'd36, 6'd38, 6'd40, 6'd42, 6'd44, 6'd47, 6'd50, 6'd53, 6'd56, 6'd59, 6'd62};
	localparam logic [5:0] TMPL_COARSE [0:20] = '{
		6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20,
		6'd22, 6'd24, 6'd26, 6'd28, 6'd30, 6'd32, 6'd35, 6'd38, 6'd42, 6'd46};

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_RANGE = 2'd1,
		ST_NOISE = 2'd2,
		ST_PATCH = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		OP_IDLE, OP_CHECK, OP_FILL, OP_POW, OP_CNT, OP_NOISE, OP_SBG, OP_PASS,
		OP_WALK, OP_POST, OP_PBUILD, OP_LFILL, OP_SORT, OP_PRUNE, OP_EMIT
	} op_t;

	typedef struct packed {
		logic       fine_scale;
		logic [2:0] start_band;
		logic [1:0] stop_band;
		logic [2:0] crossover_offset;
		logic [1:0] noise_density;
		logic       rate_48k;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] row;
		logic [5:0] master_border;
		logic [5:0] high_border;
		logic [5:0] low_border;
		logic [5:0] noise_border;
		logic [5:0] patch_border;
		logic [5:0] patch_width;
		logic [5:0] patch_source;
		logic [5:0] limiter_border;
		logic       last;
	} out_item_t;

	typedef struct packed {
		op_t  op;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic    done;
		logic    more;
		logic    fail;
		status_t code;
	} dp_sts_t;

	function automatic logic [5:0] tmpl_at(input logic hi, input logic [5:0] idx);
		logic [5:0] v;
		v = '0;
		if (hi) begin
			if (idx < 6'(MASTER_DEPTH)) v = TMPL_FINE[idx[4:0]];
		end else begin
			if (idx < 6'(MASTER_DEPTH - 2)) v = TMPL_COARSE[idx[4:0]];
		end
		return v;
	endfunction

endpackage

`default_nettype wire

/* sv/sgtd_ctrl.sv */
// controller state machine: sequences the datapath operations of one request
// depends on sgtd_pkg
`default_nettype none

module sgtd_ctrl import sgtd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output dp_cmd_t      cmd,
	input  wire dp_sts_t sts
);

	typedef enum logic [14:0] {
		S_IDLE   = 15'b000000000000001,
		S_CHECK  = 15'b000000000000010,
		S_FILL   = 15'b000000000000100,
		S_POW    = 15'b000000000001000,
		S_CNT    = 15'b000000000010000,
		S_NOISE  = 15'b000000000100000,
		S_SBG    = 15'b000000001000000,
		S_PASS   = 15'b000000010000000,
		S_WALK   = 15'b000000100000000,
		S_POST   = 15'b000001000000000,
		S_PBUILD = 15'b000010000000000,
		S_LFILL  = 15'b000100000000000,
		S_SORT   = 15'b001000000000000,
		S_PRUNE  = 15'b010000000000000,
		S_EMIT   = 15'b100000000000000
	} state_t;

	state_t state_q, next_s;

	always_comb begin
		next_s = state_q;
		cmd.load = 1'b0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.op = OP_IDLE;
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid) next_s = S_CHECK;
			end
			S_CHECK: begin
				cmd.op = OP_CHECK;
				if (sts.done) next_s = S_FILL;
			end
			S_FILL: begin
				cmd.op = OP_FILL;
				if (sts.done) next_s = S_POW;
			end
			S_POW: begin
				cmd.op = OP_POW;
				if (sts.done) next_s = S_CNT;
			end
			S_CNT: begin
				cmd.op = OP_CNT;
				if (sts.done) next_s = S_NOISE;
			end
			S_NOISE: begin
				cmd.op = OP_NOISE;
				if (sts.done) next_s = S_SBG;
			end
			S_SBG: begin
				cmd.op = OP_SBG;
				if (sts.done) next_s = S_PASS;
			end
			S_PASS: begin
				cmd.op = OP_PASS;
				if (sts.done) next_s = S_WALK;
			end
			S_WALK: begin
				cmd.op = OP_WALK;
				if (sts.done) next_s = sts.more ? S_PASS : S_POST;
			end
			S_POST: begin
				cmd.op = OP_POST;
				if (sts.done) next_s = S_PBUILD;
			end
			S_PBUILD: begin
				cmd.op = OP_PBUILD;
				if (sts.done) next_s = S_LFILL;
			end
			S_LFILL: begin
				cmd.op = OP_LFILL;
				if (sts.done) next_s = S_SORT;
			end
			S_SORT: begin
				cmd.op = OP_SORT;
				if (sts.done) next_s = S_PRUNE;
			end
			S_PRUNE: begin
				cmd.op = OP_PRUNE;
				if (sts.done) next_s = S_EMIT;
			end
			S_EMIT: begin
				cmd.op = OP_EMIT;
				if (sts.done) next_s = S_IDLE;
			end
			default: begin
				cmd.op = OP_IDLE;
				next_s = S_IDLE;
			end
		endcase
		// any failure goes straight to the single status row
		if (sts.fail) next_s = S_EMIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= next_s;
		end
	end

endmodule

`default_nettype wire

/* sv/sgtd_datapath.sv */
// datapath: table registers, loop counters and the output register
// depends on sgtd_pkg
`default_nettype none

module sgtd_datapath import sgtd_pkg::*; #(
	parameter int MAX_NOISE_GROUPS = DEF_MAX_NOISE_GROUPS,
	parameter int MAX_PATCHES = DEF_MAX_PATCHES,
	parameter int MAX_LIMITER_BANDS = DEF_MAX_LIMITER_BANDS
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire dp_cmd_t   cmd,
	input  wire in_item_t  in_item,
	output dp_sts_t        sts,
	output out_item_t      out_item,
	output logic           out_valid,
	input  wire logic      out_ready
);

	localparam int NIW = $clog2(MAX_NOISE_GROUPS + 1);
	localparam int PIW = $clog2(MAX_PATCHES + 1);
	localparam int LIM_DEPTH = LOW_DEPTH + MAX_PATCHES;
	localparam int LIW = $clog2(LIM_DEPTH);
	localparam int SHW = POW_W + 2 * MAX_NOISE_GROUPS + 3;
	localparam int PASS_MAX = 2 * (MAX_PATCHES + 2);

	in_item_t in_q;
	status_t st_q;
	logic [4:0] nm_q, nh_q, np_q, nl_q;
	logic [3:0] nlow_q, nn_q;
	logic [5:0] sba_q, sbx_q, sbz_q;

	logic [5:0] master_q [MASTER_DEPTH];
	logic [5:0] high_q [MASTER_DEPTH];
	logic [5:0] low_q [LOW_DEPTH];
	logic [5:0] noise_q [MAX_NOISE_GROUPS + 1];
	logic [5:0] pb_q [MAX_PATCHES + 1];
	logic [5:0] nsb_q [MAX_PATCHES + 1];
	logic signed [7:0] ssb_q [MAX_PATCHES + 1];
	logic [5:0] buf_q [LIM_DEPTH];

	logic [4:0] i_q, k_q, sbg_q, j_q, passes_q;
	logic [5:0] v_q, msb_q, usb_q;
	logic phase_q;
	logic [POW_W-1:0] px_q, pz_q;
	logic [2:0] pc_q;
	logic [3:0] c_q, idx_q, rem_q, d_q;
	logic [SHW-1:0] sh_q;
	out_item_t out_q;
	logic ovalid_q;

	// combinational helpers
	logic [5:0] nm_w, nh_w, base_w, goal_w, sb_w, w_w, u_w, l_w, lidx_w;
	logic [3:0] nlow_w;
	logic bad_w, odd_w, walk_w, cnt_go, sbg_go, keep_w, drop_en, isu_w, isl_w;
	logic signed [7:0] rhs_w;
	logic [4:0] np_trim, drop_w;
	logic [22:0] mu_w, ml_w;
	logic out_free;

	always_comb begin
		base_w = {2'b0, in_q.start_band, 1'b0};
		nm_w = (in_q.fine_scale ? 6'(GROUPS_FINE) : 6'(GROUPS_COARSE)) - base_w
			- {3'b0, in_q.stop_band, 1'b0};
		bad_w = (nm_w == 6'd0) || ({3'b0, in_q.crossover_offset} >= nm_w);
		nh_w = nm_w - {3'b0, in_q.crossover_offset};
		nlow_w = 4'(nh_w - {1'b0, nh_w[5:1]});
		lidx_w = (i_q == 5'd0) ? 6'd0
			: (nh_q[0] ? ({i_q, 1'b0} - 6'd1) : {i_q, 1'b0});
		goal_w = in_q.rate_48k ? 6'(GOAL_48K) : 6'(GOAL_OTHER);

		sb_w = master_q[j_q];
		odd_w = sb_w[0] ^ sba_q[0];
		rhs_w = $signed({2'b0, sba_q})
			- (in_q.fine_scale ? 8'(SRC_LOW_FINE) : 8'(SRC_LOW_COARSE))
			+ $signed({2'b0, msb_q}) - $signed({7'b0, odd_w});
		walk_w = $signed({2'b0, sb_w}) > rhs_w;
		w_w = (sb_w > usb_q) ? (sb_w - usb_q) : 6'd0;

		cnt_go = (c_q <= 4'(MAX_NOISE_GROUPS)) && (sh_q <= {{(SHW - POW_W){1'b0}}, pz_q});
		sbg_go = (goal_w < sbz_q) && (sbg_q < nm_q) && (master_q[sbg_q] < goal_w);

		np_trim = ((np_q > 5'd1) && (nsb_q[PIW'(np_q - 5'd1)] < 6'(MIN_PATCH_WIDTH)))
			? (np_q - 5'd1) : np_q;

		// limiter pruning: ratio test and patch border membership
		u_w = buf_q[i_q[LIW-1:0]];
		l_w = buf_q[LIW'(i_q - 5'd1)];
		mu_w = 23'(LIM_NUM) * {17'b0, u_w};
		ml_w = 23'(LIM_DEN) * {17'b0, l_w};
		isu_w = 1'b0;
		isl_w = 1'b0;
		for (int k = 0; k <= MAX_PATCHES; k++) begin
			if (5'(k) <= np_q && pb_q[k] == u_w) isu_w = 1'b1;
			if (5'(k) <= np_q && pb_q[k] == l_w) isl_w = 1'b1;
		end
		keep_w = 1'b0;
		drop_en = 1'b0;
		drop_w = i_q;
		if (mu_w >= ml_w) begin
			keep_w = 1'b1;
		end else if (u_w == l_w || !isu_w) begin
			drop_en = 1'b1;
		end else if (isl_w) begin
			keep_w = 1'b1;
		end else begin
			drop_en = 1'b1;
			drop_w = i_q - 5'd1;
		end

		out_free = !ovalid_q || out_ready;

		sts = '0;
		unique case (cmd.op)
			OP_IDLE: ;
			OP_CHECK: begin
				if (bad_w) begin
					sts.fail = 1'b1;
					sts.code = ST_RANGE;
				end else begin
					sts.done = 1'b1;
				end
			end
			OP_FILL: sts.done = (i_q == nm_q);
			OP_POW: sts.done = (pc_q == {in_q.noise_density, 1'b0});
			OP_CNT: begin
				sts.done = !cnt_go;
				if (!cnt_go && c_q > 4'(MAX_NOISE_GROUPS)) begin
					sts.fail = 1'b1;
					sts.code = ST_NOISE;
				end
			end
			OP_NOISE: sts.done = (rem_q < d_q) && ({1'b0, i_q} == {2'b0, nn_q});
			OP_SBG: sts.done = !sbg_go;
			OP_PASS: begin
				if (5'(passes_q + 5'd1) > 5'(PASS_MAX) || np_q > 5'(MAX_PATCHES)) begin
					sts.fail = 1'b1;
					sts.code = ST_PATCH;
				end else begin
					sts.done = 1'b1;
				end
			end
			OP_WALK: begin
				if (walk_w) begin
					if (j_q == 5'd0) begin
						sts.fail = 1'b1;
						sts.code = ST_PATCH;
					end
				end else begin
					sts.done = 1'b1;
					sts.more = (sb_w != sbz_q);
				end
			end
			OP_POST: begin
				if (np_q == 5'd0 || np_trim > 5'(MAX_PATCHES)) begin
					sts.fail = 1'b1;
					sts.code = ST_PATCH;
				end else begin
					sts.done = 1'b1;
				end
			end
			OP_PBUILD: begin
				if (i_q == np_q) begin
					sts.done = 1'b1;
				end else if (ssb_q[i_q[PIW-1:0]][7]) begin
					sts.fail = 1'b1;
					sts.code = ST_PATCH;
				end
			end
			OP_LFILL: sts.done = (i_q == nl_q);
			OP_SORT: sts.done = phase_q && (i_q > nl_q);
			OP_PRUNE: begin
				if (i_q > nl_q) begin
					if ({1'b0, nl_q} > 6'(MAX_LIMITER_BANDS)) begin
						sts.fail = 1'b1;
						sts.code = ST_PATCH;
					end else begin
						sts.done = 1'b1;
					end
				end
			end
			OP_EMIT: sts.done = out_free && (st_q != ST_OK || i_q == nm_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= in_item;
		unique case (cmd.op)
			OP_IDLE: ;
			OP_CHECK: begin
				nm_q <= nm_w[4:0];
				nh_q <= nh_w[4:0];
				nlow_q <= nlow_w;
				sba_q <= tmpl_at(in_q.fine_scale, base_w);
				sbx_q <= tmpl_at(in_q.fine_scale, 6'(base_w + {3'b0, in_q.crossover_offset}));
				sbz_q <= tmpl_at(in_q.fine_scale, 6'(base_w + nm_w));
				msb_q <= tmpl_at(in_q.fine_scale, base_w);
				usb_q <= tmpl_at(in_q.fine_scale, 6'(base_w + {3'b0, in_q.crossover_offset}));
				i_q <= '0;
				px_q <= POW_W'(1);
				pz_q <= POW_W'(1);
				pc_q <= '0;
				sbg_q <= '0;
				np_q <= '0;
				passes_q <= '0;
			end
			OP_FILL: begin
				master_q[i_q] <= tmpl_at(in_q.fine_scale, 6'(base_w + {1'b0, i_q}));
				if (i_q <= nh_q)
					high_q[i_q] <= tmpl_at(in_q.fine_scale,
						6'(base_w + {3'b0, in_q.crossover_offset} + {1'b0, i_q}));
				if ({1'b0, i_q} <= {2'b0, nlow_q})
					low_q[i_q[3:0]] <= tmpl_at(in_q.fine_scale,
						6'(base_w + {3'b0, in_q.crossover_offset} + lidx_w));
				i_q <= i_q + 5'd1;
			end
			OP_POW: begin
				if (!sts.done) begin
					px_q <= POW_W'(px_q * {{(POW_W - 6){1'b0}}, sbx_q});
					pz_q <= POW_W'(pz_q * {{(POW_W - 6){1'b0}}, sbz_q});
					pc_q <= pc_q + 3'd1;
				end else begin
					sh_q <= {{(SHW - POW_W - 1){1'b0}}, px_q, 1'b0};
					c_q <= '0;
				end
			end
			OP_CNT: begin
				if (cnt_go) begin
					c_q <= c_q + 4'd1;
					sh_q <= {sh_q[SHW-3:0], 2'b00};
				end else begin
					nn_q <= (c_q == 4'd0) ? 4'd1 : c_q;
					d_q <= (c_q == 4'd0) ? 4'd1 : c_q;
					noise_q[0] <= sbx_q;
					idx_q <= '0;
					rem_q <= nlow_q;
					i_q <= 5'd1;
				end
			end
			OP_NOISE: begin
				if (rem_q >= d_q) begin
					rem_q <= rem_q - d_q;
					idx_q <= idx_q + 4'd1;
				end else begin
					noise_q[i_q[NIW-1:0]] <= low_q[idx_q];
					i_q <= i_q + 5'd1;
					d_q <= d_q - 4'd1;
					rem_q <= nlow_q - idx_q;
				end
			end
			OP_SBG: begin
				if (sbg_go) sbg_q <= sbg_q + 5'd1;
				else if (!(goal_w < sbz_q)) sbg_q <= nm_q;
			end
			OP_PASS: begin
				passes_q <= passes_q + 5'd1;
				j_q <= sbg_q;
			end
			OP_WALK: begin
				if (walk_w) begin
					j_q <= j_q - 5'd1;
				end else begin
					nsb_q[np_q[PIW-1:0]] <= w_w;
					ssb_q[np_q[PIW-1:0]] <= $signed({2'b0, sba_q}) - $signed({7'b0, odd_w})
						- $signed({2'b0, w_w});
					if (w_w != 6'd0) begin
						usb_q <= sb_w;
						msb_q <= sb_w;
						np_q <= np_q + 5'd1;
					end else begin
						msb_q <= sbx_q;
					end
					if ($signed({1'b0, master_q[sbg_q]}) - $signed({1'b0, sb_w})
						< 7'sd3) sbg_q <= nm_q;
				end
			end
			OP_POST: begin
				np_q <= np_trim;
				pb_q[0] <= sbx_q;
				i_q <= '0;
			end
			OP_PBUILD: begin
				if (i_q != np_q) begin
					pb_q[PIW'(i_q + 5'd1)] <= pb_q[i_q[PIW-1:0]] + nsb_q[i_q[PIW-1:0]];
					i_q <= i_q + 5'd1;
				end else begin
					nl_q <= 5'({1'b0, nlow_q} + np_q - 5'd1);
					i_q <= '0;
				end
			end
			OP_LFILL: begin
				buf_q[i_q[LIW-1:0]] <= ({1'b0, i_q} <= {2'b0, nlow_q}) ? low_q[i_q[3:0]]
					: pb_q[PIW'(i_q - {1'b0, nlow_q})];
				if (sts.done) begin
					i_q <= 5'd1;
					phase_q <= 1'b1;
				end else begin
					i_q <= i_q + 5'd1;
				end
			end
			OP_SORT: begin
				if (phase_q) begin
					if (sts.done) begin
						i_q <= 5'd1;
					end else begin
						v_q <= buf_q[i_q[LIW-1:0]];
						k_q <= i_q;
						phase_q <= 1'b0;
					end
				end else if (k_q != 5'd0 && buf_q[LIW'(k_q - 5'd1)] > v_q) begin
					buf_q[k_q[LIW-1:0]] <= buf_q[LIW'(k_q - 5'd1)];
					k_q <= k_q - 5'd1;
				end else begin
					buf_q[k_q[LIW-1:0]] <= v_q;
					i_q <= i_q + 5'd1;
					phase_q <= 1'b1;
				end
			end
			OP_PRUNE: begin
				if (i_q <= nl_q) begin
					if (keep_w) begin
						i_q <= i_q + 5'd1;
					end else if (drop_en) begin
						for (int k = 0; k < LIM_DEPTH - 1; k++)
							if (5'(k) >= drop_w && 5'(k) < nl_q) buf_q[k] <= buf_q[k + 1];
						nl_q <= nl_q - 5'd1;
					end
				end else begin
					i_q <= '0;
				end
			end
			OP_EMIT: begin
				if (out_free) begin
					out_q <= '0;
					out_q.status <= st_q;
					if (st_q != ST_OK) begin
						out_q.last <= 1'b1;
					end else begin
						out_q.row <= i_q;
						out_q.master_border <= master_q[i_q];
						out_q.high_border <= (i_q <= nh_q) ? high_q[i_q] : 6'd0;
						out_q.low_border <= ({1'b0, i_q} <= {2'b0, nlow_q})
							? low_q[i_q[3:0]] : 6'd0;
						out_q.noise_border <= ({1'b0, i_q} <= {2'b0, nn_q})
							? noise_q[i_q[NIW-1:0]] : 6'd0;
						out_q.patch_border <= (i_q <= np_q) ? pb_q[i_q[PIW-1:0]] : 6'd0;
						out_q.patch_width <= (i_q < np_q) ? nsb_q[i_q[PIW-1:0]] : 6'd0;
						out_q.patch_source <= (i_q < np_q) ? ssb_q[i_q[PIW-1:0]][5:0] : 6'd0;
						out_q.limiter_border <= (i_q <= nl_q) ? buf_q[i_q[LIW-1:0]] : 6'd0;
						out_q.last <= (i_q == nm_q);
					end
					i_q <= i_q + 5'd1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			st_q <= ST_OK;
		end else begin
			if (cmd.load) st_q <= ST_OK;
			else if (sts.fail) st_q <= sts.code;
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			if (cmd.op == OP_EMIT && out_free) ovalid_q <= 1'b1;
		end
	end

	assign out_item = out_q;
	assign out_valid = ovalid_q;

endmodule

`default_nettype wire

/* sv/subband_group_table_derive_unit.sv */
// on a failed range check the controller passes from the check state to the emit state and
// the status row is registered there; otherwise the first row follows the table fill,
// the noise division steps, the patch search passes and the sort and prune walks
// throughput: one request at a time, then one result row transfer per cycle while out_ready
// reset: arst_n clears the controller and the output valid; tables are rebuilt per request
`default_nettype none

module subband_group_table_derive_unit import sgtd_pkg::*; #(
	parameter int MAX_NOISE_GROUPS = DEF_MAX_NOISE_GROUPS,
	parameter int MAX_PATCHES = DEF_MAX_PATCHES,
	parameter int MAX_LIMITER_BANDS = DEF_MAX_LIMITER_BANDS
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);

	// command and status between controller and datapath
	dp_cmd_t cmd;
	dp_sts_t sts;

	// controller: one state per table walk, loops back between pass and walk
	// for the patch search, any failure jumps to a single status row
	sgtd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// datapath: master, signal, noise, patch and limiter tables, the power test
	// multiplier, the subtract-based divider and the output register
	sgtd_datapath #(
		.MAX_NOISE_GROUPS  (MAX_NOISE_GROUPS),
		.MAX_PATCHES       (MAX_PATCHES),
		.MAX_LIMITER_BANDS (MAX_LIMITER_BANDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_item   (in_data),
		.sts       (sts),
		.out_item  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule

`default_nettype wire
